### design/lrts_pkg.sv
// Package: payload types and generator constants for the rank time scrambler.
`default_nettype none

package lrts_pkg;

  localparam int unsigned MIN_LEN   = 60;
  localparam int unsigned HOUR_LEN  = 24;

  localparam int unsigned Z_W       = 32;
  localparam int unsigned HSEED_W   = 25;
  localparam int unsigned MSEED_W   = 31;
  localparam int unsigned MULC_W    = 21;
  localparam int unsigned PROD_W    = Z_W + MULC_W;
  localparam int unsigned POS_W     = 6;

  localparam logic [Z_W-1:0]    MIN_MOD   = 32'd2147483647;
  localparam logic [MULC_W-1:0] MIN_MUL   = 21'd48271;
  localparam logic [MULC_W-1:0] HOUR_MUL  = 21'd1664525;
  localparam logic [Z_W-1:0]    HOUR_INC  = 32'd1013904223;
  localparam logic [11:0]       BASE_YEAR = 12'd2020;

  typedef struct packed {
    logic [5:0] year_offset;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour_in;
    logic [5:0] minute_in;
    logic [5:0] second_in;
  } in_t;

  typedef struct packed {
    logic [4:0] hour_out;
    logic [5:0] minute_out;
    logic [5:0] second_out;
  } out_t;

endpackage

`default_nettype wire

### design/lrts_step.sv
// Shared generator step unit: registered multiply, then modular fold or increment.
`default_nettype none

module lrts_step (
  input  wire logic                     clk,
  input  wire logic                     load,
  input  wire logic                     sel_hour,
  input  wire logic [lrts_pkg::Z_W-1:0] z_in,
  output logic      [lrts_pkg::Z_W-1:0] z_next
);
  import lrts_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [MULC_W-1:0] mul_c;
  logic [Z_W-1:0]    fold_sum;
  logic [Z_W-1:0]    min_val;
  logic [Z_W-1:0]    hour_val;

  assign mul_c    = sel_hour ? HOUR_MUL : MIN_MUL;
  assign prod_nxt = PROD_W'(z_in) * PROD_W'(mul_c);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  // fold 2^31 == 1 mod 2^31-1
  assign fold_sum = {1'b0, prod_r[30:0]} + Z_W'(prod_r[46:31]);
  assign min_val  = (fold_sum >= MIN_MOD) ? (fold_sum - MIN_MOD) : fold_sum;
  assign hour_val = prod_r[Z_W-1:0] + HOUR_INC;
  assign z_next   = sel_hour ? hour_val : min_val;

endmodule

`default_nettype wire

### design/lcg_rank_time_scrambler.sv
// Top level: sequencer that ranks generator outputs to scramble hour and minute.
//
// Usage: present a date and time word on in_data with in_valid; it is taken
// when in_ready is high. in_ready is high only while the block is idle.
// Each word starts two generator sequences, one for the minute (60 outputs)
// and one for the hour (24 outputs); each is run once up to the indexed
// output and once in full to count its rank. A single step unit, shared by
// both sequences, computes each generator output; an index out of range
// skips its sequence, whose rank is then zero.
// in_ready rises in the same cycle as out_valid for the finished word, so one
// word is in flight at a time.
// The result word sits in an output register until out_ready takes it; if
// the receiver stalls, the next finished result waits in its final state
// and no further word is accepted.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops any
// pending result.
`default_nettype none

module lcg_rank_time_scrambler (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lrts_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lrts_pkg::out_t      out_data
);
  import lrts_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SEED  = 8'b0000_0010,
    S_SEED2 = 8'b0000_0100,
    S_START = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_FOLD  = 8'b0010_0000,
    S_CMP   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t             st_r, st_nxt;
  in_t                in_r, in_nxt;
  logic [HSEED_W-1:0] hseed_r, hseed_nxt;
  logic [MSEED_W-1:0] mseed_r, mseed_nxt;
  logic [Z_W-1:0]     z_r, z_nxt;
  logic [Z_W-1:0]     tgt_r, tgt_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   cnt_r, cnt_nxt;
  logic               pass_r, pass_nxt;
  logic               hour_seq_r, hour_seq_nxt;
  logic [5:0]         min_rank_r, min_rank_nxt;
  logic [4:0]         hr_rank_r, hr_rank_nxt;
  out_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [11:0]        year;
  logic [Z_W-1:0]     seed;
  logic [POS_W-1:0]   idx;
  logic [POS_W-1:0]   last;
  logic               idx_bad;
  logic               hit;
  logic [POS_W-1:0]   cnt_inc;
  logic               step_load;
  logic [Z_W-1:0]     step_z;

  lrts_step u_step (
    .clk      (clk),
    .load     (step_load),
    .sel_hour (hour_seq_r),
    .z_in     (z_r),
    .z_next   (step_z)
  );

  assign year    = BASE_YEAR + 12'(in_r.year_offset);
  assign seed    = hour_seq_r ? Z_W'(hseed_r) : Z_W'(mseed_r);
  assign idx     = hour_seq_r ? POS_W'(in_r.hour_in) : in_r.minute_in;
  assign last    = hour_seq_r ? POS_W'(HOUR_LEN - 1) : POS_W'(MIN_LEN - 1);
  assign idx_bad = hour_seq_r ? (POS_W'(in_r.hour_in) >= POS_W'(HOUR_LEN))
                              : (in_r.minute_in >= POS_W'(MIN_LEN));
  assign hit     = (z_r < tgt_r) || ((z_r == tgt_r) && (pos_r < idx));
  assign cnt_inc = cnt_r + POS_W'(hit);

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    st_nxt        = st_r;
    in_nxt        = in_r;
    hseed_nxt     = hseed_r;
    mseed_nxt     = mseed_r;
    z_nxt         = z_r;
    tgt_nxt       = tgt_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    hour_seq_nxt  = hour_seq_r;
    min_rank_nxt  = min_rank_r;
    hr_rank_nxt   = hr_rank_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    step_load     = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt = in_data;
          st_nxt = S_SEED;
        end
      end
      S_SEED: begin
        hseed_nxt = HSEED_W'(year) * HSEED_W'(10000)
                  + HSEED_W'(in_r.month) * HSEED_W'(100)
                  + HSEED_W'(in_r.day);
        st_nxt    = S_SEED2;
      end
      S_SEED2: begin
        mseed_nxt    = MSEED_W'(hseed_r) * MSEED_W'(100) + MSEED_W'(in_r.hour_in);
        hour_seq_nxt = 1'b0;
        st_nxt       = S_START;
      end
      S_START: begin
        if (idx_bad) begin
          if (hour_seq_r) begin
            hr_rank_nxt = '0;
            st_nxt      = S_FIN;
          end else begin
            min_rank_nxt = '0;
            hour_seq_nxt = 1'b1;
          end
        end else begin
          z_nxt    = seed;
          pass_nxt = 1'b0;
          pos_nxt  = '0;
          cnt_nxt  = '0;
          st_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        step_load = 1'b1;
        st_nxt    = S_FOLD;
      end
      S_FOLD: begin
        z_nxt  = step_z;
        st_nxt = S_CMP;
      end
      S_CMP: begin
        if (!pass_r) begin
          if (pos_r == idx) begin
            tgt_nxt  = z_r;
            pass_nxt = 1'b1;
            pos_nxt  = '0;
            z_nxt    = seed;
            st_nxt   = S_MUL;
          end else begin
            pos_nxt   = pos_r + POS_W'(1);
            step_load = 1'b1;
            st_nxt    = S_FOLD;
          end
        end else begin
          cnt_nxt = cnt_inc;
          if (pos_r == last) begin
            if (hour_seq_r) begin
              hr_rank_nxt = cnt_inc[4:0];
              st_nxt      = S_FIN;
            end else begin
              min_rank_nxt = cnt_inc;
              hour_seq_nxt = 1'b1;
              st_nxt       = S_START;
            end
          end else begin
            pos_nxt   = pos_r + POS_W'(1);
            step_load = 1'b1;
            st_nxt    = S_FOLD;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.hour_out   = hr_rank_r;
          out_nxt.minute_out = min_rank_r;
          out_nxt.second_out = in_r.second_in;
          out_valid_nxt      = 1'b1;
          st_nxt             = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    hseed_r    <= hseed_nxt;
    mseed_r    <= mseed_nxt;
    z_r        <= z_nxt;
    tgt_r      <= tgt_nxt;
    pos_r      <= pos_nxt;
    cnt_r      <= cnt_nxt;
    pass_r     <= pass_nxt;
    hour_seq_r <= hour_seq_nxt;
    min_rank_r <= min_rank_nxt;
    hr_rank_r  <= hr_rank_nxt;
    out_r      <= out_nxt;
  end

`ifndef SYNTHESIS
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.minute_out < 6'd60) && (out_data.hour_out < 5'd24))
    else $error("rank out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a word while busy");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CMP) |-> (pos_r <= last))
    else $error("sequence index overran");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S_CMP) && pass_r) |-> (cnt_r <= pos_r))
    else $error("rank count exceeds outputs seen");
`endif

endmodule

`default_nettype wire
